// ===== src/sqd_pkg.sv =====
// Package for the join-shortest-queue dispatcher: widths, event codes, state type.
// Depends on nothing; used by every file under src.
package sqd_pkg;

  localparam int NUM_SERVERS_DEF = 5;
  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int CLOCK_BITS_DEF  = 16;

  localparam int SVC_W   = 8;
  localparam int KIND_W  = 2;
  localparam int IDX_W   = 3;
  localparam int WAIT_W  = 16;
  localparam int JOBS_W  = 6;
  localparam int TIME_W  = 16;

  localparam logic [KIND_W-1:0] EV_ASSIGN = 2'd0;
  localparam logic [KIND_W-1:0] EV_DEPART = 2'd1;
  localparam logic [KIND_W-1:0] EV_DROP   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_ARRIVE,
    ST_SCAN,
    ST_READ,
    ST_DEPART,
    ST_DONE
  } sqd_state_t;

endpackage

// ===== src/sqd_queue_mem.sv =====
// Shared job store: one FIFO region per server, arrival time and service time per entry.
// Imports sqd_pkg; its widths come from its parameters.
module sqd_queue_mem #(
  parameter int DEPTH  = 160,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);
  import sqd_pkg::*;

  logic [DATA_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end
endmodule

// ===== src/shortest_queue_multi_server_dispatch.sv =====
// Top level of the join-shortest-queue dispatcher: sequencer and per-server state.
// Depends on sqd_pkg and sqd_queue_mem.
//
// Usage: pulse start with in_arrival_valid and in_service_time while busy is low;
// each transfer is one tick of the simulated clock. The block then runs a small
// sequencer that reuses one job-count comparator and one time comparator,
// visiting one server per cycle except while a departing server reads its next job.
// First it finds the server with the fewest jobs, then
// places the arrival, then scans servers in order; a server whose departure is
// due and whose queue holds a job reads its next job from the shared queue memory.
// Each result appears on the out_ ports for one cycle with out_valid high;
// out_last_of_tick marks the final result of the tick. The receiver cannot stall.
// A tick with an arrival visits every server twice, in the pick pass and the scan;
// a tick without one visits each only in the scan, and each departure that starts
// a queued job adds the READ and DEPART states. A tick with neither an arrival
// nor a due departure produces no result. After reset (rst_n low, synchronous) the
// clock, all servers and all queues are empty; the queue memory needs no clearing
// because every entry is written before it is read.
module shortest_queue_multi_server_dispatch
  import sqd_pkg::*;
#(
  parameter int NUM_SERVERS = NUM_SERVERS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int CLOCK_BITS  = CLOCK_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_arrival_valid,
  input  logic [sqd_pkg::SVC_W-1:0] in_service_time,
  output logic                      out_valid,
  output logic [sqd_pkg::KIND_W-1:0] out_event_kind,
  output logic [sqd_pkg::IDX_W-1:0] out_server_index,
  output logic                      out_service_started,
  output logic [sqd_pkg::WAIT_W-1:0] out_wait_delay,
  output logic [sqd_pkg::JOBS_W-1:0] out_jobs_at_server,
  output logic [sqd_pkg::TIME_W-1:0] out_event_time,
  output logic                      out_last_of_tick
);
  import sqd_pkg::*;

  localparam int SRV_W  = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int MDEPTH = NUM_SERVERS * QUEUE_DEPTH;
  localparam int ADDR_W = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int DATA_W = CLOCK_BITS + SVC_W;
  localparam int JCNT_W = CNT_W + 1;

  sqd_state_t state_r, state_nxt;

  logic [CLOCK_BITS-1:0] clock_r;
  logic [NUM_SERVERS-1:0] sbusy_r;
  logic [CLOCK_BITS-1:0] due_r [NUM_SERVERS];
  logic [CNT_W-1:0] wcnt_r [NUM_SERVERS];
  logic [PTR_W-1:0] head_r [NUM_SERVERS];
  logic [PTR_W-1:0] tail_r [NUM_SERVERS];

  logic [SVC_W-1:0]  svc_r;
  logic [SRV_W-1:0]  idx_r;
  logic [SRV_W-1:0]  best_r;
  logic [JCNT_W-1:0] best_jobs_r;

  // Pending result: held until the next result or the tick's end so last_of_tick can be set once we know.
  logic              pend_r;
  logic [KIND_W-1:0] p_kind_r;
  logic [SRV_W-1:0]  p_srv_r;
  logic              p_start_r;
  logic [WAIT_W-1:0] p_wait_r;
  logic [JOBS_W-1:0] p_jobs_r;

  logic              emit;
  logic [KIND_W-1:0] e_kind;
  logic              e_start;
  logic [WAIT_W-1:0] e_wait;
  logic [JOBS_W-1:0] e_jobs;
  logic [SRV_W-1:0]  e_srv;

  logic [JCNT_W-1:0] jobs_idx;
  logic              last_srv;
  logic              due_now;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [DATA_W-1:0] mem_rd;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [SRV_W-1:0] s,
                                                 input logic [PTR_W-1:0] p);
    logic [ADDR_W+SRV_W+PTR_W-1:0] a;
    a = (ADDR_W+SRV_W+PTR_W)'(s) * (ADDR_W+SRV_W+PTR_W)'(QUEUE_DEPTH)
        + (ADDR_W+SRV_W+PTR_W)'(p);
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] q;
    q = {1'b0, p} + 1'b1;
    return (q >= (PTR_W+1)'(QUEUE_DEPTH)) ? '0 : q[PTR_W-1:0];
  endfunction

  assign jobs_idx = JCNT_W'(wcnt_r[idx_r]) + JCNT_W'(sbusy_r[idx_r]);
  assign last_srv = (idx_r == SRV_W'(NUM_SERVERS - 1));
  assign due_now  = sbusy_r[idx_r] && (due_r[idx_r] == clock_r);
  assign busy     = (state_r != ST_IDLE);

  sqd_queue_mem #(.DEPTH(MDEPTH), .ADDR_W(ADDR_W), .DATA_W(DATA_W)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data ({clock_r, svc_r}),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = in_arrival_valid ? ST_PICK : ST_SCAN;
      ST_PICK:   if (last_srv) state_nxt = ST_ARRIVE;
      ST_ARRIVE: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (due_now && wcnt_r[idx_r] != '0) state_nxt = ST_READ;
        else if (last_srv) state_nxt = ST_DONE;
      end
      ST_READ:   state_nxt = ST_DEPART;
      ST_DEPART: state_nxt = last_srv ? ST_DONE : ST_SCAN;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Result and memory controls for the current step.
  always_comb begin
    emit    = 1'b0;
    e_kind  = EV_ASSIGN;
    e_start = 1'b0;
    e_wait  = '0;
    e_jobs  = '0;
    e_srv   = idx_r;
    mem_we  = 1'b0;
    mem_wa  = addr_of(best_r, tail_r[best_r]);
    mem_ra  = addr_of(idx_r, head_r[idx_r]);
    case (state_r)
      ST_ARRIVE: begin
        emit  = 1'b1;
        e_srv = best_r;
        if (!sbusy_r[best_r]) begin
          e_start = 1'b1;
          e_jobs  = JOBS_W'(1);
        end else if (wcnt_r[best_r] >= CNT_W'(QUEUE_DEPTH)) begin
          e_kind = EV_DROP;
          e_jobs = JOBS_W'(best_jobs_r);
        end else begin
          mem_we = 1'b1;
          e_jobs = JOBS_W'(best_jobs_r + 1'b1);
        end
      end
      ST_SCAN: begin
        if (due_now && wcnt_r[idx_r] == '0) begin
          emit   = 1'b1;
          e_kind = EV_DEPART;
        end
      end
      ST_DEPART: begin
        emit    = 1'b1;
        e_kind  = EV_DEPART;
        e_start = 1'b1;
        e_wait  = WAIT_W'(clock_r - mem_rd[DATA_W-1:SVC_W]);
        e_jobs  = JOBS_W'(jobs_idx - 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      clock_r   <= '0;
      sbusy_r   <= '0;
      pend_r    <= 1'b0;
      out_valid <= 1'b0;
      for (int s = 0; s < NUM_SERVERS; s++) begin
        due_r[s]  <= '0;
        wcnt_r[s] <= '0;
        head_r[s] <= '0;
        tail_r[s] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            svc_r       <= in_service_time;
            idx_r       <= '0;
            best_r      <= '0;
            best_jobs_r <= '1;
          end
        end
        ST_PICK: begin
          if (jobs_idx < best_jobs_r) begin
            best_r      <= idx_r;
            best_jobs_r <= jobs_idx;
          end
          idx_r <= last_srv ? '0 : idx_r + 1'b1;
        end
        ST_ARRIVE: begin
          if (!sbusy_r[best_r]) begin
            sbusy_r[best_r] <= 1'b1;
            due_r[best_r]   <= clock_r + CLOCK_BITS'(svc_r);
          end else if (wcnt_r[best_r] < CNT_W'(QUEUE_DEPTH)) begin
            tail_r[best_r] <= step_ptr(tail_r[best_r]);
            wcnt_r[best_r] <= wcnt_r[best_r] + 1'b1;
          end
        end
        ST_SCAN: begin
          if (due_now && wcnt_r[idx_r] == '0) sbusy_r[idx_r] <= 1'b0;
          if (!(due_now && wcnt_r[idx_r] != '0) && !last_srv) idx_r <= idx_r + 1'b1;
        end
        ST_DEPART: begin
          head_r[idx_r] <= step_ptr(head_r[idx_r]);
          wcnt_r[idx_r] <= wcnt_r[idx_r] - 1'b1;
          due_r[idx_r]  <= clock_r + CLOCK_BITS'(mem_rd[SVC_W-1:0]);
          if (!last_srv) idx_r <= idx_r + 1'b1;
        end
        ST_DONE: begin
          clock_r <= clock_r + 1'b1;
        end
        default: ;
      endcase

      // A held result goes out when the next one arrives or the tick ends.
      if (state_r != ST_IDLE && (emit || state_r == ST_DONE) && pend_r) begin
        out_valid           <= 1'b1;
        out_event_kind      <= p_kind_r;
        out_server_index    <= IDX_W'(p_srv_r);
        out_service_started <= p_start_r;
        out_wait_delay      <= p_wait_r;
        out_jobs_at_server  <= p_jobs_r;
        out_event_time      <= TIME_W'(clock_r);
        out_last_of_tick    <= (state_r == ST_DONE);
      end
      if (emit) begin
        pend_r    <= 1'b1;
        p_kind_r  <= e_kind;
        p_srv_r   <= e_srv;
        p_start_r <= e_start;
        p_wait_r  <= e_wait;
        p_jobs_r  <= e_jobs;
      end else if (state_r == ST_DONE) begin
        pend_r <= 1'b0;
      end
    end
  end
endmodule

// ===== src/sqd_checker.sv =====
// Port-level checker for the dispatcher, bound to the top level.
// Depends on sqd_pkg for event codes and field widths.
module sqd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [sqd_pkg::KIND_W-1:0] out_event_kind,
  input logic                       out_service_started,
  input logic [sqd_pkg::WAIT_W-1:0] out_wait_delay,
  input logic [sqd_pkg::JOBS_W-1:0] out_jobs_at_server,
  input logic                       out_last_of_tick
);
  import sqd_pkg::*;

  a_drop_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_DROP |-> !out_service_started)
    else $error("dropped arrival reports a started job");

  a_wait_only_started: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_service_started |-> out_wait_delay == '0)
    else $error("wait reported without a service start");

  a_idle_departure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_DEPART && !out_service_started
      |-> out_jobs_at_server == '0)
    else $error("server going idle reports jobs");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted tick did not raise busy");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_tick |=> !out_valid)
    else $error("result after last of tick");
endmodule

bind shortest_queue_multi_server_dispatch sqd_checker u_sqd_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the join-shortest-queue dispatcher.
// Depends on sqd_pkg and on shortest_queue_multi_server_dispatch under src.
`timescale 1ns / 100ps

module testbench;
  import sqd_pkg::*;

  localparam int NSRV = NUM_SERVERS_DEF;
  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  // Cycles without any transfer on either side before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Extra cycles allowed after the last expected result arrives.
  localparam int DRAIN_CYCLES = 60;

  // One result of the dispatcher as the output ports carry it.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  srv;
    logic              started;
    logic [WAIT_W-1:0] wait_ticks;
    logic [JOBS_W-1:0] jobs;
    logic [TIME_W-1:0] tick_stamp;
    logic              last;
  } dispatch_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_arrival_valid = 1'b0;
  logic [SVC_W-1:0] in_service_time = '0;
  logic out_valid;
  logic [KIND_W-1:0] out_event_kind;
  logic [IDX_W-1:0] out_server_index;
  logic out_service_started;
  logic [WAIT_W-1:0] out_wait_delay;
  logic [JOBS_W-1:0] out_jobs_at_server;
  logic [TIME_W-1:0] out_event_time;
  logic out_last_of_tick;

  shortest_queue_multi_server_dispatch uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_arrival_valid    (in_arrival_valid),
    .in_service_time     (in_service_time),
    .out_valid           (out_valid),
    .out_event_kind      (out_event_kind),
    .out_server_index    (out_server_index),
    .out_service_started (out_service_started),
    .out_wait_delay      (out_wait_delay),
    .out_jobs_at_server  (out_jobs_at_server),
    .out_event_time      (out_event_time),
    .out_last_of_tick    (out_last_of_tick)
  );

  always #5 clk = ~clk;

  // The predictor keeps its own copy of the simulated clock, of each server and
  // of each server's waiting line.
  logic [TIME_W-1:0] sim_now;
  logic              srv_busy [NSRV];
  logic [TIME_W-1:0] srv_due [NSRV];
  int                srv_waiting [NSRV];
  int                line_head [NSRV];
  int                line_tail [NSRV];
  logic [TIME_W-1:0] line_arrival [NSRV][QDEPTH];
  logic [SVC_W-1:0]  line_service [NSRV][QDEPTH];

  dispatch_event_t pending_events[$];
  int error_count = 0;
  bit sender_pauses = 1'b0;

  function automatic int jobs_held(int s);
    return srv_waiting[s] + (srv_busy[s] ? 1 : 0);
  endfunction

  // Applies one accepted tick to the predicted state and queues the results it causes.
  task automatic predict_tick(input logic arrive, input logic [SVC_W-1:0] svc);
    dispatch_event_t ev;
    int n_before;
    int best;
    int p;
    n_before = pending_events.size();
    best = 0;
    if (arrive) begin
      for (int s = 1; s < NSRV; s++) begin
        if (jobs_held(s) < jobs_held(best)) best = s;
      end
      ev = '0;
      ev.srv = best[IDX_W-1:0];
      ev.tick_stamp = sim_now;
      if (!srv_busy[best]) begin
        // An idle server begins the job at once with no wait.
        srv_busy[best] = 1'b1;
        srv_due[best] = sim_now + TIME_W'(svc);
        ev.kind = EV_ASSIGN;
        ev.started = 1'b1;
      end else if (srv_waiting[best] >= QDEPTH) begin
        // The chosen line is full, so the job is turned away.
        ev.kind = EV_DROP;
      end else begin
        p = line_tail[best];
        line_arrival[best][p] = sim_now;
        line_service[best][p] = svc;
        line_tail[best] = (p + 1) % QDEPTH;
        srv_waiting[best]++;
        ev.kind = EV_ASSIGN;
      end
      ev.jobs = JOBS_W'(jobs_held(best));
      pending_events.insert(pending_events.size(), ev);
    end
    // Departures are scanned in server order after the arrival is placed.
    for (int s = 0; s < NSRV; s++) begin
      if (srv_busy[s] && srv_due[s] == sim_now) begin
        ev = '0;
        ev.kind = EV_DEPART;
        ev.srv = s[IDX_W-1:0];
        ev.tick_stamp = sim_now;
        if (srv_waiting[s] > 0) begin
          p = line_head[s];
          line_head[s] = (p + 1) % QDEPTH;
          srv_waiting[s]--;
          srv_due[s] = sim_now + TIME_W'(line_service[s][p]);
          ev.started = 1'b1;
          ev.wait_ticks = sim_now - line_arrival[s][p];
          ev.jobs = JOBS_W'(jobs_held(s));
        end else begin
          srv_busy[s] = 1'b0;
        end
        pending_events.insert(pending_events.size(), ev);
      end
    end
    if (pending_events.size() > n_before)
      pending_events[pending_events.size() - 1].last = 1'b1;
    sim_now = sim_now + 1'b1;
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    error_count++;
  endtask

  // Sends one tick. The sender may pause first for a random burst of cycles.
  task automatic send_tick(input logic arrive, input logic [SVC_W-1:0] svc);
    if (sender_pauses && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    start = 1'b1;
    in_arrival_valid = arrive;
    in_service_time = svc;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_tick(arrive, svc);
    @(negedge clk);
    start = 1'b0;
    in_arrival_valid = 1'($urandom_range(0, 1));
    in_service_time = SVC_W'($urandom);
  endtask

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    dispatch_event_t want;
    if (rst_n && out_valid) begin
      if (pending_events.size() == 0) begin
        report_mismatch("results pending", 0, 1);
      end else begin
        want = pending_events[0];
        pending_events.delete(0);
        if (out_event_kind !== want.kind)
          report_mismatch("event_kind", int'(out_event_kind), int'(want.kind));
        if (out_server_index !== want.srv)
          report_mismatch("server_index", int'(out_server_index), int'(want.srv));
        if (out_service_started !== want.started)
          report_mismatch("service_started", int'(out_service_started),
                          int'(want.started));
        if (out_wait_delay !== want.wait_ticks)
          report_mismatch("wait_delay", int'(out_wait_delay), int'(want.wait_ticks));
        if (out_jobs_at_server !== want.jobs)
          report_mismatch("jobs_at_server", int'(out_jobs_at_server), int'(want.jobs));
        if (out_event_time !== want.tick_stamp)
          report_mismatch("event_time", int'(out_event_time), int'(want.tick_stamp));
        if (out_last_of_tick !== want.last)
          report_mismatch("last_of_tick", int'(out_last_of_tick), int'(want.last));
      end
    end
  end

  // The watchdog ends a run in which no transfer happens for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Extremes of the fields, a zero service job that leaves in its own tick, a quiet
  // tick, a queued arrival and the shortest-line choice with ties.
  task automatic test_directed();
    send_tick(1'b1, 8'd0);
    send_tick(1'b0, 8'hFF);
    send_tick(1'b0, 8'h00);
    send_tick(1'b1, 8'hFF);
    for (int i = 0; i < 6; i++) send_tick(1'b1, SVC_W'(i + 1));
    send_tick(1'b1, 8'hAA);
    send_tick(1'b1, 8'h55);
    for (int i = 0; i < 8; i++) send_tick(1'b0, 8'h00);
    send_tick(1'b1, 8'd1);
    send_tick(1'b1, 8'd0);
  endtask

  // Back-to-back long jobs fill every line until arrivals are dropped.
  task automatic test_full_lines();
    for (int i = 0; i < NSRV * (QDEPTH + 1) + 15; i++) send_tick(1'b1, 8'hFF);
  endtask

  // Zero service jobs are queued behind busy servers, so they start on a departure
  // and stay in service until the clock comes back around; quiet ticks follow.
  task automatic test_clock_wrap();
    for (int i = 0; i < 8; i++) send_tick(1'b1, 8'd0);
    for (int i = 0; i < 40; i++) send_tick(1'b0, SVC_W'($urandom));
  endtask

  // Random ticks: mostly arrivals with short service so lines build up and drain.
  task automatic test_random(input int count);
    logic [SVC_W-1:0] svc;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: svc = SVC_W'($urandom);
        1: svc = SVC_W'($urandom_range(0, 3));
        default: svc = SVC_W'($urandom_range(0, 15));
      endcase
      send_tick($urandom_range(0, 9) < 6, svc);
    end
  endtask

  initial begin
    sim_now = '0;
    for (int s = 0; s < NSRV; s++) begin
      srv_busy[s] = 1'b0;
      srv_due[s] = '0;
      srv_waiting[s] = 0;
      line_head[s] = 0;
      line_tail[s] = 0;
    end
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    sender_pauses = 1'b1;
    test_random(250);
    sender_pauses = 1'b0;
    test_clock_wrap();
    test_full_lines();
    // Wait until every expected result has arrived, then a little longer.
    while (pending_events.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
